// ===== rtl/qos_credit_lane_arbiter_top_assert.svh =====
// Assertion macros shared by the arbiter RTL
`ifndef QOS_CREDIT_LANE_ARBITER_TOP_ASSERT_SVH
`define QOS_CREDIT_LANE_ARBITER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define QCLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset
`define QCLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/qcla_pkg.sv =====
// ----------------------------------------------------------------------------
// qcla_pkg
// Types, constants and codes shared by the lane arbiter files.
// ----------------------------------------------------------------------------
package qcla_pkg;
	localparam int NUM_LANES_DEF  = 4;
	localparam int FIFO_DEPTH_DEF = 16;
	localparam int NUM_REGS       = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CREDIT = 2'd1,
		OP_POP    = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		SET_NONE = 2'd0,
		SET_ELIG = 2'd1,
		SET_CAP  = 2'd2
	} lset_t;

	typedef enum logic [1:0] {
		MODE_MIN  = 2'd0,
		MODE_MAX  = 2'd1,
		MODE_NONE = 2'd2
	} mode_t;

	localparam logic [2:0] REG_MODES = 3'd0;
	localparam logic [2:0] REG_PRIO  = 3'd1;
	localparam logic [2:0] REG_DLY0  = 3'd2;
	localparam logic [2:0] REG_DLY1  = 3'd3;
	localparam logic [2:0] REG_DLY2  = 3'd4;
	localparam logic [2:0] REG_DLY3  = 3'd5;
	localparam logic [2:0] REG_LINK  = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_SCAN,
		ST_PICK,
		ST_MUL1,
		ST_MUL2,
		ST_ADV,
		ST_ARM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] bytes;
	} entry_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  lane;
		logic [15:0] packet_bytes;
		logic [15:0] packet_tag;
		logic [31:0] credit_amount;
		logic [47:0] now_cycle;
	} req_t;

	typedef struct packed {
		logic        popped_valid;
		logic [15:0] popped_tag;
		logic [1:0]  popped_lane;
		logic [15:0] popped_bytes;
		logic        nothing_ready;
		logic [1:0]  error_code;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_t;

	function automatic mode_t mode_decode(input logic [1:0] m);
		mode_t r;
		r = (m == 2'd0) ? MODE_MIN : ((m == 2'd1) ? MODE_MAX : MODE_NONE);
		return r;
	endfunction
endpackage

// ===== rtl/qcla_stream_if.sv =====
// ----------------------------------------------------------------------------
// qcla_stream_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface qcla_req_if;
	logic             valid;
	logic             ready;
	qcla_pkg::req_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface qcla_rsp_if;
	logic             valid;
	logic             ready;
	qcla_pkg::rsp_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface qcla_cfg_if;
	logic             valid;
	logic             ready;
	qcla_pkg::cfg_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/qos_credit_lane_arbiter_top.sv =====
// ----------------------------------------------------------------------------
// qos_credit_lane_arbiter_top
// Four-lane credit based QoS output arbiter with a shared sequencer.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (insert packet, add credits, pop next packet);
// exactly one response per request leaves on rsp. Configuration registers are
// written on cfg (index 0..6); the user must write them only while the block
// is idle, as the block itself does not enforce it; cfg is always ready.
// A request is taken only in the idle state. Its work runs in a sequencer that
// uses one 16x32 multiplier over steps. A pop with work queued runs through the
// scan (one lane compared per cycle), a pick/read step, two multiplier steps,
// an advance step and a re-arm step; insert, credit, the unused code and a pop
// with nothing ready skip them. With a ready receiver the next request is taken
// in the cycle after the response is accepted.
// The response sits in an output register; a stalled receiver holds it and
// the block takes no new request until it has been delivered.
// Reset clears all lane state and config registers (link delay becomes 1);
// queue memory contents are left as they are, never used before written.
// ----------------------------------------------------------------------------
module qos_credit_lane_arbiter_top #(
	parameter int FIFO_DEPTH = qcla_pkg::FIFO_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	qcla_req_if.sink   req,
	qcla_rsp_if.source rsp,
	qcla_cfg_if.sink   cfg
);
`include "qos_credit_lane_arbiter_top_assert.svh"

	// lane count is fixed by the register layout
	localparam int NUM_LANES = qcla_pkg::NUM_LANES_DEF;
	localparam int LW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
	localparam int QW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int AW = LW + QW;
	localparam int SLOTS = 1 << QW;
	localparam logic [63:0] MAX64 = {64{1'b1}};

	// configuration registers
	logic [7:0]  modes_q;
	logic [31:0] prio_q;
	logic [31:0] dly_q [4];
	logic [31:0] link_q;

	// lane state
	logic [QW-1:0] head_q  [NUM_LANES];
	logic [CW-1:0] count_q [NUM_LANES];
	logic [31:0]   credit_q[NUM_LANES];
	logic [63:0]   nf_q    [NUM_LANES];
	logic          stall_q [NUM_LANES];
	qcla_pkg::lset_t set_q [NUM_LANES];

	// queue memory
	qcla_pkg::entry_t mem [NUM_LANES*SLOTS];
	qcla_pkg::entry_t rd_q;
	logic [AW-1:0]    raddr;
	logic             rd_en;
	logic             wr_en;
	logic [AW-1:0]    waddr;
	qcla_pkg::entry_t wdata;

	// sequencer
	qcla_pkg::state_t state_q, state_d;
	qcla_pkg::req_t   r_q;
	qcla_pkg::rsp_t   out_q;
	logic             out_v_q;
	logic [LW-1:0]    lane_q;     // working lane
	logic             lane_ok_q;
	logic [LW:0]      scan_q;
	logic [LW-1:0]    best_q;
	logic             best_v_q;
	logic             any_elig_q;
	logic [63:0]      mul_q;      // shared multiplier result
	logic [63:0]      normal_q;

	// helpers
	function automatic logic [1:0] mode_raw(input logic [7:0] m, input int l);
		return (l < 4) ? m[2*(l%4) +: 2] : 2'd0;
	endfunction

	qcla_pkg::mode_t lmode;
	logic [31:0]     ldly;
	logic [15:0]     hb;
	logic [63:0]     now64;
	logic [31:0]     mul_a;
	logic [15:0]     mul_b;
	logic [47:0]     mul_p;

	assign now64 = {16'd0, r_q.now_cycle};

	always_comb begin
		lmode = qcla_pkg::mode_decode(mode_raw(modes_q, int'(lane_q)));
		ldly  = (int'(lane_q) < 4) ? dly_q[lane_q[LW-1:0] & LW'(3)] : 32'd0;
		hb    = rd_q.bytes;
	end

	// ring slot arithmetic for the working lane
	logic [QW:0]   tail_sum;
	logic [QW-1:0] tail_slot;
	logic [QW-1:0] head_nx;
	assign tail_sum  = {1'b0, head_q[lane_q]} + (QW+1)'(count_q[lane_q]);
	assign tail_slot = (int'(tail_sum) >= FIFO_DEPTH) ?
		QW'(tail_sum - (QW+1)'(FIFO_DEPTH)) : QW'(tail_sum);
	assign head_nx   = (int'(head_q[lane_q]) == FIFO_DEPTH - 1) ? '0 :
		head_q[lane_q] + QW'(1);

	logic ins_ok;
	assign ins_ok = (r_q.operation == qcla_pkg::OP_INSERT) && lane_ok_q &&
		(int'(count_q[lane_q]) < FIFO_DEPTH);

	// shared multiplier: 16 x 32 bits
	assign mul_p = mul_a * {32'd0, mul_b};

	logic all_empty;
	always_comb begin
		all_empty = 1'b1;
		for (int i = 0; i < NUM_LANES; i++)
			if (set_q[i] != qcla_pkg::SET_NONE) all_empty = 1'b0;
	end

	// any lane eligible once due capped lanes are promoted
	logic promo_elig;
	always_comb begin
		promo_elig = 1'b0;
		for (int i = 0; i < NUM_LANES; i++)
			if (set_q[i] == qcla_pkg::SET_ELIG ||
				(set_q[i] == qcla_pkg::SET_CAP && nf_q[i] <= now64))
				promo_elig = 1'b1;
	end

	// scan lane values
	logic [LW-1:0] sl;
	qcla_pkg::lset_t sset;
	logic [7:0] sprio, bprio;
	assign sl = scan_q[LW-1:0];
	always_comb begin
		sset  = set_q[sl];
		sprio = (int'(sl) < 4) ? prio_q[8*(int'(sl)%4) +: 8] : 8'd0;
		bprio = (int'(best_q) < 4) ? prio_q[8*(int'(best_q)%4) +: 8] : 8'd0;
	end
	logic take;
	always_comb begin
		take = 1'b0;
		if (any_elig_q) begin
			if (sset == qcla_pkg::SET_ELIG)
				take = !best_v_q || (sprio > bprio) ||
					(sprio == bprio && nf_q[sl] < nf_q[best_q]);
		end else if (sset == qcla_pkg::SET_CAP) begin
			take = !best_v_q || (nf_q[sl] < nf_q[best_q]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qcla_pkg::ST_IDLE: if (req.valid && req.ready) state_d = qcla_pkg::ST_FETCH;
			qcla_pkg::ST_FETCH: state_d = qcla_pkg::ST_EXEC;
			qcla_pkg::ST_EXEC: begin
				if (r_q.operation == qcla_pkg::OP_POP && !all_empty)
					state_d = qcla_pkg::ST_SCAN;
				else
					state_d = qcla_pkg::ST_OUT;
			end
			qcla_pkg::ST_SCAN:
				if (int'(scan_q) == NUM_LANES - 1) state_d = qcla_pkg::ST_PICK;
			qcla_pkg::ST_PICK: state_d = qcla_pkg::ST_MUL1;
			qcla_pkg::ST_MUL1: state_d = qcla_pkg::ST_MUL2;
			qcla_pkg::ST_MUL2: state_d = qcla_pkg::ST_ADV;
			qcla_pkg::ST_ADV: state_d = qcla_pkg::ST_ARM;
			qcla_pkg::ST_ARM: state_d = qcla_pkg::ST_OUT;
			qcla_pkg::ST_OUT: if (!out_v_q || rsp.ready) state_d = qcla_pkg::ST_IDLE;
			default: state_d = qcla_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready   = (state_q == qcla_pkg::ST_IDLE) && !out_v_q;
		cfg.ready   = 1'b1;
		rsp.valid   = out_v_q;
		rsp.payload = out_q;
	end

	// memory address selection
	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		if (state_q == qcla_pkg::ST_IDLE) begin
			rd_en = 1'b1;
			raddr = {req.payload.lane[LW-1:0], head_q[req.payload.lane[LW-1:0]]};
		end else if (state_q == qcla_pkg::ST_PICK) begin
			rd_en = 1'b1;
			raddr = {best_q, head_q[best_q]};
		end else if (state_q == qcla_pkg::ST_ADV) begin
			rd_en = 1'b1;
			raddr = {lane_q, head_nx};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= wdata;
		if (rd_en) rd_q <= mem[raddr];
	end

	// multiplier operand select
	always_comb begin
		mul_a = ldly;
		mul_b = hb;
		if (state_q == qcla_pkg::ST_MUL2) mul_a = link_q;
		if (state_q == qcla_pkg::ST_FETCH) mul_b = r_q.packet_bytes;
	end

	// main datapath
	logic [32:0] csum;
	logic [31:0] cnew;
	assign csum = {1'b0, credit_q[lane_q]} + {1'b0, r_q.credit_amount};
	assign cnew = csum[32] ? 32'hFFFF_FFFF : csum[31:0];

	logic [63:0] deficit;
	assign deficit = (now64 > nf_q[lane_q]) ? now64 - nf_q[lane_q] : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= qcla_pkg::ST_IDLE;
			out_v_q    <= 1'b0;
			modes_q    <= '0;
			prio_q     <= '0;
			for (int i = 0; i < 4; i++) dly_q[i] <= '0;
			link_q     <= 32'd1;
			for (int i = 0; i < NUM_LANES; i++) begin
				head_q[i]   <= '0;
				count_q[i]  <= '0;
				credit_q[i] <= '0;
				nf_q[i]     <= '0;
				stall_q[i]  <= 1'b0;
				set_q[i]    <= qcla_pkg::SET_NONE;
			end
			wr_en      <= 1'b0;
			scan_q     <= '0;
			best_q     <= '0;
			best_v_q   <= 1'b0;
			any_elig_q <= 1'b0;
			lane_q     <= '0;
			lane_ok_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_en   <= (state_q == qcla_pkg::ST_EXEC) && ins_ok;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.payload.index)
					qcla_pkg::REG_MODES: modes_q <= cfg.payload.data[7:0];
					qcla_pkg::REG_PRIO:  prio_q <= cfg.payload.data;
					qcla_pkg::REG_LINK:  link_q <= cfg.payload.data;
					qcla_pkg::REG_DLY0, qcla_pkg::REG_DLY1, qcla_pkg::REG_DLY2,
					qcla_pkg::REG_DLY3:
						dly_q[2'(cfg.payload.index - qcla_pkg::REG_DLY0)] <= cfg.payload.data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			unique case (state_q)
				qcla_pkg::ST_IDLE: if (req.valid && req.ready) begin
					r_q       <= req.payload;
					lane_q    <= req.payload.lane[LW-1:0];
					lane_ok_q <= (int'(req.payload.lane) < NUM_LANES);
					out_q     <= '0;
				end
				qcla_pkg::ST_FETCH: mul_q <= {16'd0, mul_p};
				qcla_pkg::ST_EXEC: begin
					// insert / credit / pop setup
					if (r_q.operation == qcla_pkg::OP_INSERT && lane_ok_q) begin
						if (int'(count_q[lane_q]) >= FIFO_DEPTH) begin
							out_q.error_code <= qcla_pkg::ERR_FULL;
						end else begin
							if (count_q[lane_q] == '0) begin
								if (credit_q[lane_q] >= {16'd0, r_q.packet_bytes}) begin
									credit_q[lane_q] <= credit_q[lane_q] -
										{16'd0, r_q.packet_bytes};
									unique case (lmode)
										qcla_pkg::MODE_NONE: begin
											nf_q[lane_q]  <= MAX64;
											set_q[lane_q] <= qcla_pkg::SET_ELIG;
										end
										qcla_pkg::MODE_MIN: begin
											nf_q[lane_q]  <= now64 + mul_q;
											set_q[lane_q] <= qcla_pkg::SET_ELIG;
										end
										default: begin
											if (nf_q[lane_q] > now64) begin
												set_q[lane_q] <= qcla_pkg::SET_CAP;
											end else begin
												nf_q[lane_q]  <= now64;
												set_q[lane_q] <= qcla_pkg::SET_ELIG;
											end
										end
									endcase
								end else begin
									stall_q[lane_q] <= 1'b1;
								end
							end
							waddr   <= {lane_q, tail_slot};
							wdata   <= {r_q.packet_tag, r_q.packet_bytes};
							count_q[lane_q] <= count_q[lane_q] + CW'(1);
						end
					end else if (r_q.operation == qcla_pkg::OP_CREDIT && lane_ok_q) begin
						if (stall_q[lane_q] && count_q[lane_q] != '0 &&
							{16'd0, hb} <= cnew) begin
							set_q[lane_q] <= (lmode == qcla_pkg::MODE_MAX) ?
								qcla_pkg::SET_CAP : qcla_pkg::SET_ELIG;
							credit_q[lane_q] <= cnew - {16'd0, hb};
							stall_q[lane_q]  <= 1'b0;
						end else begin
							credit_q[lane_q] <= cnew;
							if (stall_q[lane_q] && count_q[lane_q] == '0)
								stall_q[lane_q] <= 1'b0;
						end
					end else if (r_q.operation == qcla_pkg::OP_POP) begin
						if (all_empty) begin
							out_q.error_code <= qcla_pkg::ERR_EMPTY;
						end else begin
							// promote capped lanes whose time has come
							for (int i = 0; i < NUM_LANES; i++) begin
								if (set_q[i] == qcla_pkg::SET_CAP && nf_q[i] <= now64)
									set_q[i] <= qcla_pkg::SET_ELIG;
							end
							any_elig_q <= promo_elig;
							scan_q   <= '0;
							best_v_q <= 1'b0;
						end
					end
				end
				qcla_pkg::ST_SCAN: begin
					if (take) begin
						best_q   <= sl;
						best_v_q <= 1'b1;
					end
					scan_q <= scan_q + (LW+1)'(1);
				end
				qcla_pkg::ST_PICK: begin
					lane_q <= best_q;
				end
				qcla_pkg::ST_MUL1: begin
					// pop the chosen lane; normal gap = bytes * lane delay
					normal_q <= {16'd0, mul_p};
					set_q[lane_q] <= qcla_pkg::SET_NONE;
					if (!best_v_q || count_q[lane_q] == '0) begin
						out_q.error_code <= qcla_pkg::ERR_EMPTY;
					end else begin
						out_q.popped_valid <= 1'b1;
						out_q.popped_tag   <= rd_q.tag;
						out_q.popped_bytes <= rd_q.bytes;
						out_q.popped_lane  <= 2'(lane_q);
					end
				end
				qcla_pkg::ST_MUL2: begin
					mul_q <= {16'd0, mul_p};
				end
				qcla_pkg::ST_ADV: begin
					if (out_q.popped_valid) begin
						if (lmode == qcla_pkg::MODE_MAX)
							nf_q[lane_q] <= (deficit >= normal_q) ? now64 + mul_q :
								now64 + mul_q + (normal_q - deficit);
						head_q[lane_q]  <= head_nx;
						count_q[lane_q] <= count_q[lane_q] - CW'(1);
					end
				end
				qcla_pkg::ST_ARM: begin
					// re-arm the lane with its new head (rd_q now holds it)
					if (out_q.popped_valid && count_q[lane_q] != '0) begin
						if (credit_q[lane_q] >= {16'd0, hb}) begin
							credit_q[lane_q] <= credit_q[lane_q] - {16'd0, hb};
							unique case (lmode)
								qcla_pkg::MODE_NONE: begin
									nf_q[lane_q]  <= now64;
									set_q[lane_q] <= qcla_pkg::SET_ELIG;
								end
								qcla_pkg::MODE_MIN: begin
									nf_q[lane_q]  <= now64 + {16'd0, mul_p};
									set_q[lane_q] <= qcla_pkg::SET_ELIG;
								end
								default: set_q[lane_q] <= qcla_pkg::SET_CAP;
							endcase
						end else begin
							stall_q[lane_q] <= 1'b1;
							if (lmode == qcla_pkg::MODE_MIN)
								nf_q[lane_q] <= now64 + {16'd0, mul_p};
						end
					end
				end
				qcla_pkg::ST_OUT: if (!out_v_q || rsp.ready) begin
					out_v_q <= 1'b1;
					out_q.nothing_ready <= all_empty;
				end
				default: ;
			endcase
		end
	end

	// checks
	`QCLA_ASSERT_IMP(a_rdy_idle, clk, arst_n, req.ready, state_q == qcla_pkg::ST_IDLE)
	`QCLA_ASSERT_NEXT(a_one_rsp, clk, arst_n, req.valid && req.ready, !rsp.valid)
	`QCLA_ASSERT_IMP(a_pop_err, clk, arst_n, rsp.valid && rsp.payload.popped_valid,
		rsp.payload.error_code == qcla_pkg::ERR_OK)

endmodule

// ===== tb/sv/tb_qos_credit_lane_arbiter_top.sv =====
// ----------------------------------------------------------------------------
// tb_qos_credit_lane_arbiter_top
// Self-checking bench for the four-lane credit QoS arbiter. A queue-fed
// driver sends insert, credit, pop and unused-code requests. A behavioral
// lane model predicts every response, and a monitor compares each field in
// order. The run steps through several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_qos_credit_lane_arbiter_top;
	import qcla_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LANES = NUM_LANES_DEF;
	localparam int DEPTH = FIFO_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qcla_req_if req();
	qcla_rsp_if rsp();
	qcla_cfg_if cfg();

	qos_credit_lane_arbiter_top dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	always #6 clk = ~clk;

	// predicted lane arbiter state
	logic [7:0]  m_modes;
	logic [31:0] m_prio;
	logic [31:0] m_delay [LANES];
	logic [31:0] m_link;
	entry_t      m_fifo [LANES][DEPTH];
	int          m_head [LANES];
	int          m_count [LANES];
	logic [31:0] m_credit [LANES];
	logic [63:0] m_free [LANES];
	logic        m_stall [LANES];
	lset_t       m_set [LANES];

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   errors = 0;
	int   pops_seen = 0;
	int   empty_seen = 0;
	int   full_seen = 0;
	int   cycles = 0;
	logic [47:0] clock_now = '0;

	function automatic mode_t lane_mode(int l);
		logic [1:0] m;
		m = m_modes[2*l +: 2];
		return (m == 2'd0) ? MODE_MIN : ((m == 2'd1) ? MODE_MAX : MODE_NONE);
	endfunction

	function automatic logic [7:0] lane_prio(int l);
		return m_prio[8*l +: 8];
	endfunction

	function automatic logic nothing_queued();
		foreach (m_set[l]) if (m_set[l] != SET_NONE) return 1'b0;
		return 1'b1;
	endfunction

	// model state after reset
	function automatic void reset_model();
		m_modes = '0;
		m_prio = '0;
		m_link = 32'd1;
		for (int l = 0; l < LANES; l++) begin
			m_delay[l] = '0;
			m_head[l] = 0;
			m_count[l] = 0;
			m_credit[l] = '0;
			m_free[l] = '0;
			m_stall[l] = 1'b0;
			m_set[l] = SET_NONE;
		end
	endfunction

	// load the head of a non-empty lane, or stall it for credits
	function automatic void rearm_lane(int l, logic [63:0] now);
		logic [15:0] b;
		logic [63:0] deadline;
		b = m_fifo[l][m_head[l]].bytes;
		deadline = now + 64'(b) * 64'(m_delay[l]);
		if (m_credit[l] >= 32'(b)) begin
			m_credit[l] -= 32'(b);
			case (lane_mode(l))
				MODE_NONE: begin m_free[l] = now; m_set[l] = SET_ELIG; end
				MODE_MIN: begin m_free[l] = deadline; m_set[l] = SET_ELIG; end
				default: m_set[l] = SET_CAP;
			endcase
		end else begin
			m_stall[l] = 1'b1;
			if (lane_mode(l) == MODE_MIN) m_free[l] = deadline;
		end
	endfunction

	function automatic rsp_t arbitrate(req_t r);
		rsp_t o;
		int l, best;
		logic any_elig;
		logic [63:0] now, deficit, normal, xmit, nf;
		logic [32:0] sum;
		logic [15:0] hb;
		o = '0;
		l = int'(r.lane);
		now = 64'(r.now_cycle);
		case (op_t'(r.operation))
			OP_INSERT: begin
				if (m_count[l] >= DEPTH) begin
					o.error_code = ERR_FULL;
				end else begin
					if (m_count[l] == 0) begin
						if (m_credit[l] >= 32'(r.packet_bytes)) begin
							m_credit[l] -= 32'(r.packet_bytes);
							case (lane_mode(l))
								MODE_NONE: begin
									m_free[l] = '1;
									m_set[l] = SET_ELIG;
								end
								MODE_MIN: begin
									m_free[l] = now + 64'(r.packet_bytes) * 64'(m_delay[l]);
									m_set[l] = SET_ELIG;
								end
								default: begin
									if (m_free[l] > now) m_set[l] = SET_CAP;
									else begin
										m_free[l] = now;
										m_set[l] = SET_ELIG;
									end
								end
							endcase
						end else m_stall[l] = 1'b1;
					end
					m_fifo[l][(m_head[l] + m_count[l]) % DEPTH] = '{r.packet_tag, r.packet_bytes};
					m_count[l]++;
				end
			end
			OP_CREDIT: begin
				sum = 33'(m_credit[l]) + 33'(r.credit_amount);
				m_credit[l] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				if (m_stall[l]) begin
					if (m_count[l] == 0) m_stall[l] = 1'b0;
					else begin
						hb = m_fifo[l][m_head[l]].bytes;
						if (32'(hb) <= m_credit[l]) begin
							m_set[l] = (lane_mode(l) == MODE_MAX) ? SET_CAP : SET_ELIG;
							m_credit[l] -= 32'(hb);
							m_stall[l] = 1'b0;
						end
					end
				end
			end
			OP_POP: begin
				if (nothing_queued()) begin
					o.error_code = ERR_EMPTY;
				end else begin
					any_elig = 1'b0;
					best = LANES;
					for (int i = 0; i < LANES; i++) begin
						if (m_set[i] == SET_CAP && m_free[i] <= now) m_set[i] = SET_ELIG;
						if (m_set[i] == SET_ELIG) any_elig = 1'b1;
					end
					for (int i = 0; i < LANES; i++) begin
						if (any_elig) begin
							if (m_set[i] != SET_ELIG) continue;
							if (best == LANES || lane_prio(i) > lane_prio(best) ||
								(lane_prio(i) == lane_prio(best) && m_free[i] < m_free[best]))
								best = i;
						end else begin
							if (m_set[i] != SET_CAP) continue;
							if (best == LANES || m_free[i] < m_free[best]) best = i;
						end
					end
					m_set[best] = SET_NONE;
					if (m_count[best] == 0) o.error_code = ERR_EMPTY;
					else begin
						o.popped_valid = 1'b1;
						o.popped_tag = m_fifo[best][m_head[best]].tag;
						o.popped_bytes = m_fifo[best][m_head[best]].bytes;
						o.popped_lane = 2'(best);
						m_head[best] = (m_head[best] + 1) % DEPTH;
						m_count[best]--;
						if (lane_mode(best) == MODE_MAX) begin
							nf = m_free[best];
							deficit = (now > nf) ? now - nf : 64'd0;
							normal = 64'(o.popped_bytes) * 64'(m_delay[best]);
							xmit = 64'(o.popped_bytes) * 64'(m_link);
							m_free[best] = (deficit >= normal) ? now + xmit
								: now + xmit + (normal - deficit);
						end
						if (m_count[best] != 0) rearm_lane(best, now);
					end
				end
			end
			default: ;
		endcase
		o.nothing_ready = nothing_queued();
		return o;
	endfunction

	// request driver: valid holds until the request is taken
	logic req_taken = 1'b0;
	always @(posedge clk) req_taken <= arst_n && req.valid && req.ready;

	always @(negedge clk) begin
		logic v;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.payload <= '0;
			rsp.ready <= 1'b0;
		end else begin
			v = req.valid;
			if (req_taken) begin
				void'(pending_reqs.pop_front());
				v = 1'b0;
			end
			if (!v && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
				v = 1'b1;
			req.valid <= v;
			if (v) req.payload <= pending_reqs[0];
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// register writes take effect in the model at the handshake;
	// predict at request accept, check at response accept
	always @(posedge clk) begin
		rsp_t e, a;
		cycles <= cycles + 1;
		if (!arst_n) begin
			reset_model();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.payload.index)
					REG_MODES: m_modes = cfg.payload.data[7:0];
					REG_PRIO: m_prio = cfg.payload.data;
					REG_LINK: m_link = cfg.payload.data;
					default: m_delay[cfg.payload.index - REG_DLY0] = cfg.payload.data;
				endcase
			end
			if (req.valid && req.ready)
				expected_rsps.insert(expected_rsps.size(), arbitrate(req.payload));
			if (rsp.valid && rsp.ready) begin
				a = rsp.payload;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response, expected none, got %h", $time, a);
					errors++;
				end else begin
					e = expected_rsps.pop_front();
					if (a !== e) begin
						$display("%0t: mismatch exp valid=%b tag=%h lane=%0d bytes=%h nr=%b err=%0d",
							$time, e.popped_valid, e.popped_tag, e.popped_lane, e.popped_bytes,
							e.nothing_ready, e.error_code);
						$display("%0t:          got valid=%b tag=%h lane=%0d bytes=%h nr=%b err=%0d",
							$time, a.popped_valid, a.popped_tag, a.popped_lane, a.popped_bytes,
							a.nothing_ready, a.error_code);
						errors++;
					end
					if (e.popped_valid) pops_seen++;
					if (e.error_code == ERR_EMPTY) empty_seen++;
					if (e.error_code == ERR_FULL) full_seen++;
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, expected_rsps.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_req(op_t op, int l, logic [15:0] b, logic [15:0] t,
		logic [31:0] c, logic [47:0] now);
		req_t r;
		r.operation = op;
		r.lane = 2'(l);
		r.packet_bytes = b;
		r.packet_tag = t;
		r.credit_amount = c;
		r.now_cycle = now;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req.valid);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.payload <= '{idx, data};
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic program_lanes(logic [7:0] modes, logic [31:0] prio, logic [31:0] dly,
		logic [31:0] link);
		write_reg(REG_MODES, {24'($urandom), modes});
		write_reg(REG_PRIO, prio);
		for (int i = 0; i < LANES; i++)
			write_reg(REG_DLY0 + 3'(i), (i == 3) ? ~dly : dly + 32'(i));
		write_reg(REG_LINK, link);
	endtask

	// random traffic: mostly small packets on a mostly rising clock
	task automatic random_traffic(int n);
		int k;
		logic [15:0] b;
		logic [31:0] c;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			clock_now += 48'($urandom_range(0, 3000));
			if ($urandom_range(49) == 0) clock_now = {$urandom, 16'($urandom)};
			b = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
			c = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 4000));
			if (k < 40) push_req(OP_INSERT, $urandom_range(3), b, 16'($urandom), $urandom,
				clock_now);
			else if (k < 65) push_req(OP_CREDIT, $urandom_range(3), 16'($urandom),
				16'($urandom), c, {$urandom, 16'($urandom)});
			else if (k < 96) push_req(OP_POP, $urandom_range(3), 16'($urandom),
				16'($urandom), $urandom, clock_now);
			else push_req(OP_NOP, $urandom_range(3), 16'($urandom), 16'($urandom),
				$urandom, {$urandom, 16'($urandom)});
		end
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.payload = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset defaults, empty pop, unused op, saturation, extremes
		push_req(OP_POP, 0, 16'h0, 16'h0, 32'h0, 48'h0);
		push_req(OP_NOP, 3, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		push_req(OP_INSERT, 0, 16'h0, 16'hFFFF, 32'h0, 48'h10);
		push_req(OP_CREDIT, 1, 16'h0, 16'h0, 32'hFFFF_FFFF, 48'h0);
		push_req(OP_CREDIT, 1, 16'h0, 16'h0, 32'hFFFF_FFFF, 48'h0);
		push_req(OP_INSERT, 1, 16'hFFFF, 16'h0, 32'h0, 48'hFFFF_FFFF_FFFF);
		push_req(OP_POP, 2, 16'h0, 16'h0, 32'h0, 48'hFFFF_FFFF_FFFF);
		push_req(OP_POP, 1, 16'h0, 16'h0, 32'h0, 48'hFFFF_FFFF_FFFF);
		// fill lane 3 past its depth with no credits, then release it
		for (int i = 0; i < DEPTH + 1; i++)
			push_req(OP_INSERT, 3, 16'(i + 1), 16'(16'hA000 + i), 32'h0, 48'h20);
		push_req(OP_CREDIT, 3, 16'h0, 16'h0, 32'd200, 48'h0);
		push_req(OP_POP, 3, 16'h0, 16'h0, 32'h0, 48'h30);
		push_req(OP_POP, 3, 16'h0, 16'h0, 32'h0, 48'h40);
		drain();

		// no-QoS lanes with near-maximum delays on lanes 0 to 2 and zero link delay
		program_lanes(8'hFA, 32'h01FF_0080, 32'hFFFF_FFF0, 32'h0);
		random_traffic(130);
		drain();

		// bandwidth cap lanes, sender gaps
		send_idle_pct = 67;
		program_lanes(8'h55, 32'h0102_0304, 32'd3, 32'hFFFF_FFFF);
		random_traffic(60);
		drain();
		random_traffic(70);
		drain();

		// mixed modes, receiver stalls
		send_idle_pct = 0;
		recv_stall_pct = 67;
		program_lanes(8'hE4, 32'hFFFF_0000, 32'd0, 32'd2);
		random_traffic(130);
		drain();

		// minimum bandwidth lanes, both sides idle
		send_idle_pct = 30;
		recv_stall_pct = 30;
		program_lanes(8'h00, 32'h0, 32'd7, 32'd1);
		random_traffic(130);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		program_lanes(8'h9C, $urandom, 32'd1, 32'd4);
		random_traffic(80);
		drain();

		$display("Covered %0d packet pops, %0d empty pops and %0d full-queue drops",
			pops_seen, empty_seen, full_seen);
		$display("across six register settings and four idle/stall mixes");
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
